// File: rtl/btds_pkg.sv
// ----------------------------------------------------------------------------
// btds_pkg
// shared types, constants and helpers for the byte translator
// ----------------------------------------------------------------------------
package btds_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int IDX_W        = $clog2(SYMBOL_COUNT);
	localparam logic [8:0] SYMBOL_LIMIT = 9'(SYMBOL_COUNT);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes of the config port
	localparam logic CFG_DELETE  = 1'b0;
	localparam logic CFG_SQUEEZE = 1'b1;

	typedef enum logic {
		REQ_DATA  = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic delete_en;
		logic squeeze_en;
	} cfg_t;

	// queue entry: data -> key is the mapped byte, flag is first-set membership
	//              write -> key is the table index, flag is the second-set bit
	typedef struct packed {
		req_kind_t  kind;
		logic [7:0] key;
		logic       flag;
	} qent_t;

	function automatic logic in_table(input logic [7:0] v);
		in_table = ({1'b0, v} < SYMBOL_LIMIT);
	endfunction

endpackage

// File: rtl/byte_translate_delete_squeeze.sv
// ----------------------------------------------------------------------------
// byte_translate_delete_squeeze
// byte-stream translator with delete and squeeze over a loadable table
// ----------------------------------------------------------------------------
// a kept data byte passes the front stage, queue, back stage and output register to m_tvalid
// throughput: one request per cycle while the queue has room, set by the
// single-port reads of the front (translate/first-set) and back (second-set) tables
// reset: arst_n clears control, config and per-entry valid bits at once;
// tables read as identity / not-in-set until written, no clearing pass
// ----------------------------------------------------------------------------
module byte_translate_delete_squeeze (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] byte_value, [15:8] map_value, [16] first_set_flag,
	// [17] second_set_flag, [23:18] zero
	input  logic [23:0] s_tdata,
	// [0] req_type (0 data byte, 1 table write)
	input  logic        s_tuser,
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	btds_pkg::cfg_t  cfg_q;
	btds_pkg::qent_t push_ent;
	btds_pkg::qent_t head_ent;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	// config registers; the user must write them only while the block is idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				btds_pkg::CFG_DELETE:  cfg_q.delete_en  <= cfg_data;
				btds_pkg::CFG_SQUEEZE: cfg_q.squeeze_en <= cfg_data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	// front: takes requests, looks up the mapped byte and first-set flag,
	// drops deleted bytes before they reach the queue
	btds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_ent)
	);

	// decoupling queue: table writes and data keep their order through it
	btds_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_ent),
		.pop    (q_pop),
		.rdata  (head_ent),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: second-set lookup on the mapped byte, squeeze against the last
	// emitted byte, output register
	btds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (head_ent),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: rtl/btds_front.sv
// ----------------------------------------------------------------------------
// btds_front
// accepts requests, owns the translate/first-set table, applies delete
// ----------------------------------------------------------------------------
module btds_front (
	input  logic                clk,
	input  logic                arst_n,
	input  btds_pkg::cfg_t      cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,
	input  logic                s_tuser,
	input  logic                q_full,
	output logic                q_push,
	output btds_pkg::qent_t     q_data
);

	logic [btds_pkg::IDX_W-1:0] idx;
	logic                       in_rng;
	logic                       accept;
	logic                       is_write;

	logic [8:0]                 tbl_mem [btds_pkg::SYMBOL_COUNT];
	logic [8:0]                 rd_q;
	logic [btds_pkg::SYMBOL_COUNT-1:0] vld_q;

	logic                       s1_valid_q;
	btds_pkg::req_kind_t        kind_s1;
	logic [7:0]                 byte_s1;
	logic                       flag2_s1;
	logic                       hit_s1;

	logic [7:0]                 coded;
	logic                       in_first;
	logic                       keep;

	assign idx      = s_tdata[btds_pkg::IDX_W-1:0];
	assign in_rng   = btds_pkg::in_table(s_tdata[7:0]);
	assign is_write = (s_tuser == btds_pkg::REQ_WRITE);

	// stage 1 decode
	assign coded    = hit_s1 ? rd_q[8:1] : byte_s1;
	assign in_first = hit_s1 & rd_q[0];
	assign keep     = (kind_s1 == btds_pkg::REQ_WRITE) || !(cfg.delete_en && in_first);

	assign s_tready = !s1_valid_q || !keep || !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = s1_valid_q && keep && !q_full;

	always_comb begin
		q_data.kind = kind_s1;
		if (kind_s1 == btds_pkg::REQ_WRITE) begin
			q_data.key  = byte_s1;
			q_data.flag = flag2_s1;
		end else begin
			q_data.key  = coded;
			q_data.flag = in_first;
		end
	end

	// table storage: write on a table request, registered read on a data request
	always_ff @(posedge clk) begin
		if (accept && in_rng) begin
			if (is_write) begin
				tbl_mem[idx] <= {s_tdata[15:8], s_tdata[16]};
			end else begin
				rd_q <= tbl_mem[idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept && in_rng && is_write) begin
				vld_q[idx] <= 1'b1;
			end
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= btds_pkg::req_kind_t'(s_tuser);
			byte_s1  <= s_tdata[7:0];
			flag2_s1 <= s_tdata[17];
			hit_s1   <= in_rng && !is_write && vld_q[idx];
		end
	end

endmodule

// File: rtl/btds_fifo.sv
// ----------------------------------------------------------------------------
// btds_fifo
// short request queue between the front and back halves
// ----------------------------------------------------------------------------
module btds_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  btds_pkg::qent_t  wdata,
	input  logic             pop,
	output btds_pkg::qent_t  rdata,
	output logic             full,
	output logic             empty
);

	btds_pkg::qent_t                 ent_q [btds_pkg::QUEUE_DEPTH];
	logic [btds_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [btds_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [btds_pkg::QCNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == btds_pkg::QCNT_W'(btds_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/btds_back.sv
// ----------------------------------------------------------------------------
// btds_back
// second-set table, squeeze decision and output register
// ----------------------------------------------------------------------------
module btds_back (
	input  logic                clk,
	input  logic                arst_n,
	input  btds_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  btds_pkg::qent_t     q_data,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata
);

	logic [btds_pkg::IDX_W-1:0]        idx;
	logic                              in_rng;
	logic                              pop_write;
	logic                              pop_data;

	logic                              sec_mem [btds_pkg::SYMBOL_COUNT];
	logic                              rd_q;
	logic [btds_pkg::SYMBOL_COUNT-1:0] vld_q;

	logic                              s2_valid_q;
	logic [7:0]                        coded_s2;
	logic                              first_s2;
	logic                              hit_s2;

	logic                              in_second;
	logic                              drop;
	logic                              s2_go;
	logic                              s2_load;

	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	logic [7:0]                        last_q;
	logic                              last_valid_q;

	assign idx    = q_data.key[btds_pkg::IDX_W-1:0];
	assign in_rng = btds_pkg::in_table(q_data.key);

	assign in_second = hit_s2 & rd_q;
	assign drop      = cfg.squeeze_en && last_valid_q && (last_q == coded_s2)
		&& (first_s2 || in_second);
	assign s2_go     = s2_valid_q && (drop || !out_valid_q || m_tready);
	assign s2_load   = !s2_valid_q || s2_go;

	assign q_pop     = !q_empty && s2_load;
	assign pop_write = q_pop && (q_data.kind == btds_pkg::REQ_WRITE);
	assign pop_data  = q_pop && (q_data.kind == btds_pkg::REQ_DATA);

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_byte_q;

	always_ff @(posedge clk) begin
		if (in_rng) begin
			if (pop_write) begin
				sec_mem[idx] <= q_data.flag;
			end else if (pop_data) begin
				rd_q <= sec_mem[idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_data) begin
			coded_s2 <= q_data.key;
			first_s2 <= q_data.flag;
			hit_s2   <= in_rng && vld_q[idx];
		end
		if (s2_go && !drop) begin
			out_byte_q <= coded_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			s2_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			last_q       <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (pop_write && in_rng) begin
				vld_q[idx] <= 1'b1;
			end
			if (s2_load) begin
				s2_valid_q <= pop_data;
			end
			if (s2_go && !drop) begin
				out_valid_q  <= 1'b1;
				last_q       <= coded_s2;
				last_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the byte translator against a predictor of its own: table writes and
// data bytes go in through the request stream under several delete/squeeze
// settings, and every output byte is compared in order with the predicted one
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 12;    // covers the front, back and output registers plus queue
	localparam int HOLD_LEN    = 400;   // long receiver hold-off

	// one request as the sender sees it
	typedef struct packed {
		btds_pkg::req_kind_t kind;
		logic [7:0]          byte_value;
		logic [7:0]          map_value;
		logic                first_flag;
		logic                second_flag;
	} byte_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;

	byte_translate_delete_squeeze dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor state: its own copy of the tables, last byte and config
	// ------------------------------------------------------------------
	logic [7:0] map_table  [btds_pkg::SYMBOL_COUNT];
	logic       first_set  [btds_pkg::SYMBOL_COUNT];
	logic       second_set [btds_pkg::SYMBOL_COUNT];
	logic [7:0] last_out;
	logic       last_out_valid;
	logic       del_on;
	logic       sqz_on;

	byte_req_t  req_queue[$];   // requests waiting for the driver
	logic [7:0] bytes_due[$];   // output bytes still to come, oldest first

	byte_req_t  offered;        // request currently on the stream
	logic       req_taken = 1'b0;
	logic       calm = 1'b0;        // no idling on either side
	logic       hold_phase = 1'b0;  // asks the receiver for one long hold-off
	int         err_cnt = 0;
	int         cycle_cnt = 0;

	// work out what one accepted request does to the tables and the output
	function automatic void predict_request(input byte_req_t r);
		logic [7:0] mapped;
		logic       hit_first;
		logic       hit_second;
		if (r.kind == btds_pkg::REQ_WRITE) begin
			if (int'(r.byte_value) < btds_pkg::SYMBOL_COUNT) begin
				map_table[r.byte_value]  = r.map_value;
				first_set[r.byte_value]  = r.first_flag;
				second_set[r.byte_value] = r.second_flag;
			end
			return;
		end
		// bytes past the table map to themselves and sit in neither set
		if (int'(r.byte_value) < btds_pkg::SYMBOL_COUNT) begin
			mapped    = map_table[r.byte_value];
			hit_first = first_set[r.byte_value];
		end else begin
			mapped    = r.byte_value;
			hit_first = 1'b0;
		end
		hit_second = (int'(mapped) < btds_pkg::SYMBOL_COUNT) ? second_set[mapped] : 1'b0;
		if (del_on && hit_first)
			return;
		// squeeze only once something has gone out
		if (sqz_on && last_out_valid && last_out == mapped && (hit_first || hit_second))
			return;
		last_out       = mapped;
		last_out_valid = 1'b1;
		bytes_due.push_back(mapped);
	endfunction

	function automatic void note_error(input string msg);
		if (err_cnt < 10)
			$display("%0t: %s", $realtime, msg);
		err_cnt++;
	endfunction

	// ------------------------------------------------------------------
	// driver: request side, sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				predict_request(offered);
			// config writes only happen while idle, so no overlap with requests
			if (cfg_we) begin
				case (cfg_index)
					btds_pkg::CFG_DELETE:  del_on = cfg_data;
					btds_pkg::CFG_SQUEEZE: sqz_on = cfg_data;
					default:               ;
				endcase
			end
		end
	end

	// driver: request side, driven at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			// a request stays up until taken
			if (!s_tvalid || req_taken) begin
				if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
					offered = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= offered.kind;
					s_tdata  <= {6'b0, offered.second_flag, offered.first_flag,
					             offered.map_value, offered.byte_value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random back-pressure plus one long hold-off on request
	// ------------------------------------------------------------------
	int   hold_cnt = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_phase && !hold_done) begin
				hold_cnt  <= HOLD_LEN;
				hold_done <= 1'b1;
				m_tready  <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: each output byte against the oldest expected one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (bytes_due.size() == 0) begin
				note_error($sformatf("unexpected out_byte %02h", m_tdata));
			end else begin
				want = bytes_due.pop_front();
				if (m_tdata !== want)
					note_error($sformatf("out_byte mismatch: expected %02h got %02h",
					                     want, m_tdata));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[byte_translate_delete_squeeze] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_data(input logic [7:0] b);
		byte_req_t r;
		r             = '0;
		r.kind        = btds_pkg::REQ_DATA;
		r.byte_value  = b;
		// unused fields still toggle on data requests
		r.map_value   = 8'($urandom);
		r.first_flag  = 1'($urandom);
		r.second_flag = 1'($urandom);
		req_queue.push_back(r);
	endtask

	task automatic push_write(input logic [7:0] idx, input logic [7:0] mv,
	                          input logic f1, input logic f2);
		byte_req_t r;
		r.kind        = btds_pkg::REQ_WRITE;
		r.byte_value  = idx;
		r.map_value   = mv;
		r.first_flag  = f1;
		r.second_flag = f2;
		req_queue.push_back(r);
	endtask

	// wait until every request is taken and every output byte has come
	task automatic drain();
		while (req_queue.size() != 0 || s_tvalid || req_taken || bytes_due.size() != 0)
			@(posedge clk);
	endtask

	// idle block: let any trailing table write leave the pipe, then set both
	task automatic set_mode(input logic del, input logic sqz);
		drain();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= btds_pkg::CFG_DELETE;
		cfg_data  <= del;
		@(negedge clk);
		cfg_index <= btds_pkg::CFG_SQUEEZE;
		cfg_data  <= sqz;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// well-formed traffic: small symbol pool so maps collide and squeeze hits
	task automatic random_traffic(input int n);
		logic [7:0] prev;
		int         roll;
		prev = 8'h00;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 14) begin
				push_write(($urandom_range(0, 3) == 0) ? 8'($urandom)
				                                       : 8'($urandom_range(0, 15)),
				           ($urandom_range(0, 2) == 0) ? 8'($urandom)
				                                       : 8'($urandom_range(0, 7)),
				           1'($urandom), 1'($urandom));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 35)
					push_data(prev);          // runs of the same byte
				else if (roll < 80)
					prev = 8'($urandom_range(0, 15));
				else
					prev = 8'($urandom);
				if (roll >= 35)
					push_data(prev);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < btds_pkg::SYMBOL_COUNT; i++) begin
			map_table[i]  = 8'(i);
			first_set[i]  = 1'b0;
			second_set[i] = 1'b0;
		end
		last_out       = 8'h00;
		last_out_valid = 1'b0;
		del_on         = 1'b0;
		sqz_on         = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// squeeze on before anything has gone out
		set_mode(1'b0, 1'b1);
		push_write(8'h00, 8'h00, 1'b1, 1'b0);
		push_data(8'h00);                       // first byte is never squeezed
		push_data(8'h00);                       // repeat, input in first set
		push_write(8'hFF, 8'hFF, 1'b0, 1'b1);
		push_data(8'hFF);
		push_data(8'hFF);                       // repeat, mapped in second set
		push_data(8'h7E);
		push_data(8'h7E);                       // repeat outside both sets
		push_write(8'h80, 8'h7E, 1'b0, 1'b0);
		push_data(8'h80);                       // same mapped byte, no set hit
		push_write(8'h01, 8'hFF, 1'b1, 1'b1);
		push_data(8'hFF);
		push_data(8'h01);                       // maps onto last byte, first set

		// delete only
		set_mode(1'b1, 1'b0);
		push_data(8'h00);
		push_data(8'h01);
		push_data(8'hFF);
		push_data(8'hFF);
		push_write(8'h55, 8'hAA, 1'b0, 1'b0);
		push_data(8'h55);
		push_data(8'hAA);

		// both on, receiver holds off long while the sender keeps going
		set_mode(1'b1, 1'b1);
		hold_phase = 1'b1;
		random_traffic(250);

		// squeeze only, no idling anywhere
		set_mode(1'b0, 1'b1);
		calm = 1'b1;
		random_traffic(250);
		drain();
		calm = 1'b0;

		// delete only, sender pauses halfway until everything is out
		set_mode(1'b1, 1'b0);
		random_traffic(125);
		drain();
		random_traffic(125);

		// plain translation
		set_mode(1'b0, 1'b0);
		random_traffic(200);

		// random settings
		for (int p = 0; p < 2; p++) begin
			set_mode(1'($urandom), 1'($urandom));
			random_traffic(100);
		end

		set_mode(1'b1, 1'b1);
		random_traffic(150);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("[byte_translate_delete_squeeze] OK");
		else
			$display("[byte_translate_delete_squeeze] ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/btds_pkg.sv
rtl/btds_front.sv
rtl/btds_fifo.sv
rtl/btds_back.sv
rtl/byte_translate_delete_squeeze.sv
verif/testbench.sv
